// ===== hdl/knps_pkg.sv =====
// shared types and constants of the k nearest point select block
package knps_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBits    = 24;
  localparam int unsigned IdBits       = 16;
  localparam int unsigned LimitBits    = 7;
  localparam int unsigned ResultCap    = 64;
  localparam int unsigned KBits        = $clog2(ResultCap + 1);
  localparam int unsigned ProdBits     = 2 * CoordBits;
  localparam int unsigned DistBits     = 2 * CoordBits + 2;
  localparam int unsigned CfgIdxBits   = 2;

  localparam logic [CfgIdxBits-1:0] CfgMaxTargets = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgOriginX    = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgOriginY    = 2'd2;
  localparam logic [CfgIdxBits-1:0] CfgOriginZ    = 2'd3;

  typedef struct packed {
    logic [IdBits-1:0]           point_id;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic                        last_point;
  } point_req_t;

  typedef struct packed {
    logic [IdBits-1:0] target_id;
    logic              last_target;
    logic              set_truncated;
  } target_rsp_t;

  typedef enum logic [1:0] {
    AxisX,
    AxisY,
    AxisZ
  } axis_e;

  typedef struct packed {
    logic  capture;
    logic  mul_en;
    axis_e axis;
    logic  acc_load;
    logic  acc_add;
    logic  store;
    logic  sel_init;
    logic  rd_k;
    logic  scan_start;
    logic  scan_step;
    logic  emit;
    logic  set_clear;
  } knps_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic want_done;
    logic load_order;
    logic scan_done;
    logic out_free;
  } knps_sts_t;

endpackage

// ===== hdl/knps_ctrl.sv =====
// controller state machine for loading points and selecting targets
module knps_ctrl import knps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output knps_cmd_t cmd_o,
  input  knps_sts_t sts_i
);

  typedef enum logic [3:0] {
    StIdle,
    StMulX,
    StMulY,
    StMulZ,
    StStore,
    StSelect,
    StNext,
    StScan,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.axis = AxisX;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.capture = 1'b1;
          state_d = StMulX;
        end
      end
      StMulX: begin
        if (sts_i.skip) begin
          state_d = sts_i.last ? StSelect : StIdle;
        end else begin
          cmd_o.mul_en = 1'b1;
          cmd_o.axis   = AxisX;
          state_d = StMulY;
        end
      end
      StMulY: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.axis     = AxisY;
        cmd_o.acc_load = 1'b1;
        state_d = StMulZ;
      end
      StMulZ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.axis    = AxisZ;
        cmd_o.acc_add = 1'b1;
        state_d = StStore;
      end
      StStore: begin
        cmd_o.store = 1'b1;
        state_d = sts_i.last ? StSelect : StIdle;
      end
      StSelect: begin
        cmd_o.sel_init = 1'b1;
        state_d = StNext;
      end
      StNext: begin
        if (sts_i.want_done) begin
          cmd_o.set_clear = 1'b1;
          state_d = StIdle;
        end else if (sts_i.load_order) begin
          cmd_o.rd_k = 1'b1;
          state_d = StEmit;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_done) begin
          state_d = StEmit;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = StNext;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == StIdle);
    end
  end

  assign in_ready_o = in_ready_q;

endmodule

// ===== hdl/knps_dpath.sv =====
// datapath: config registers, distance unit, point store, nearest scan and output register
module knps_dpath import knps_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  knps_cmd_t             cmd_i,
  output knps_sts_t             sts_o,
  input  point_req_t            in_req_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output target_rsp_t           out_rsp_o
);

  localparam int unsigned CntW  = $clog2(MaxPoints + 1);
  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned WantW = (CntW > LimitBits) ? CntW : LimitBits;

  typedef struct packed {
    logic [IdBits-1:0]   id;
    logic [DistBits-1:0] sq_dist;
  } entry_t;

  function automatic logic [CoordBits-1:0] abs_diff(input logic signed [CoordBits-1:0] a,
                                                    input logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] d;
    logic [CoordBits:0]        m;
    d = $signed({a[CoordBits-1], a}) - $signed({b[CoordBits-1], b});
    m = d[CoordBits] ? ((CoordBits + 1)'(0) - $unsigned(d)) : $unsigned(d);
    return m[CoordBits-1:0];
  endfunction

  // configuration
  logic [LimitBits-1:0]        max_targets_q;
  logic signed [CoordBits-1:0] origin_x_q, origin_y_q, origin_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_targets_q <= LimitBits'(1);
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      origin_z_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMaxTargets: max_targets_q <= cfg_wdata_i[LimitBits-1:0];
        CfgOriginX:    origin_x_q    <= cfg_wdata_i;
        CfgOriginY:    origin_y_q    <= cfg_wdata_i;
        CfgOriginZ:    origin_z_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control registers
  logic [CntW-1:0]  count_q, scan_addr_q;
  logic             ovf_q, skip_q, last_q, load_order_q, first_q;
  logic             cmp_vld_q, found_q, out_valid_q;
  logic [KBits-1:0] want_q, k_q;

  // payload registers
  logic [IdBits-1:0]    id_q;
  logic [CoordBits-1:0] dx_q, dy_q, dz_q;
  logic [ProdBits-1:0]  prod_q;
  logic [DistBits-1:0]  acc_q;
  entry_t               store_q [MaxPoints];
  entry_t               rdata_q;
  logic [AddrW-1:0]     cmp_idx_q, best_idx_q, prev_idx_q;
  logic [DistBits-1:0]  best_dist_q, prev_dist_q;
  logic [IdBits-1:0]    best_id_q;
  target_rsp_t          out_rsp_q;

  logic                 full;
  logic [CoordBits-1:0] mul_a;
  logic [ProdBits-1:0]  sq;
  logic [DistBits-1:0]  dist_sum;
  logic [WantW-1:0]     n_w, mt_w, want_w, k_ext;
  logic                 lo;
  logic [KBits-1:0]     want_d, k_inc;
  logic                 scan_more, rd_en, elig, take;
  logic [AddrW-1:0]     rd_addr;

  assign full = (count_q == CntW'(MaxPoints));

  always_comb begin
    case (cmd_i.axis)
      AxisX:   mul_a = dx_q;
      AxisY:   mul_a = dy_q;
      AxisZ:   mul_a = dz_q;
      default: mul_a = dx_q;
    endcase
  end

  assign sq       = ProdBits'(mul_a) * ProdBits'(mul_a);
  assign dist_sum = acc_q + DistBits'(prod_q);

  // result count for this set
  assign n_w    = WantW'(count_q);
  assign mt_w   = WantW'(max_targets_q);
  assign lo     = !ovf_q && (n_w <= mt_w);
  assign want_w = lo ? n_w : ((mt_w < n_w) ? mt_w : n_w);
  assign want_d = (want_w > WantW'(ResultCap)) ? KBits'(ResultCap) : want_w[KBits-1:0];
  assign k_inc  = k_q + KBits'(1);
  assign k_ext  = WantW'(k_q);

  assign scan_more = (scan_addr_q != count_q);
  assign rd_en     = cmd_i.rd_k || (cmd_i.scan_step && scan_more);
  assign rd_addr   = cmd_i.rd_k ? k_ext[AddrW-1:0] : scan_addr_q[AddrW-1:0];

  // next pick is the smallest (distance, index) above the previous pick
  assign elig = first_q || (rdata_q.sq_dist > prev_dist_q) ||
                ((rdata_q.sq_dist == prev_dist_q) && (cmp_idx_q > prev_idx_q));
  assign take = cmp_vld_q && elig && (!found_q || (rdata_q.sq_dist < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q <= in_req_i.point_id;
      dx_q <= abs_diff(in_req_i.pos_x, origin_x_q);
      dy_q <= abs_diff(in_req_i.pos_y, origin_y_q);
      dz_q <= abs_diff(in_req_i.pos_z, origin_z_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= sq;
    end
    if (cmd_i.acc_load) begin
      acc_q <= DistBits'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= dist_sum;
    end
    if (cmd_i.store) begin
      store_q[count_q[AddrW-1:0]] <= '{id: id_q, sq_dist: dist_sum};
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
    if (cmd_i.scan_step && scan_more) begin
      cmp_idx_q <= scan_addr_q[AddrW-1:0];
    end
    if (take) begin
      best_dist_q <= rdata_q.sq_dist;
      best_idx_q  <= cmp_idx_q;
      best_id_q   <= rdata_q.id;
    end
    if (cmd_i.emit) begin
      prev_dist_q             <= best_dist_q;
      prev_idx_q              <= best_idx_q;
      out_rsp_q.target_id     <= load_order_q ? rdata_q.id : best_id_q;
      out_rsp_q.last_target   <= (k_inc == want_q);
      out_rsp_q.set_truncated <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      skip_q       <= 1'b0;
      last_q       <= 1'b0;
      want_q       <= '0;
      k_q          <= '0;
      load_order_q <= 1'b0;
      first_q      <= 1'b1;
      scan_addr_q  <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        skip_q <= full;
        last_q <= in_req_i.last_point;
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.store) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.sel_init) begin
        want_q       <= want_d;
        load_order_q <= lo;
        k_q          <= '0;
        first_q      <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        cmp_vld_q   <= 1'b0;
        found_q     <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (scan_more) begin
          scan_addr_q <= scan_addr_q + CntW'(1);
          cmp_vld_q   <= 1'b1;
        end else begin
          cmp_vld_q <= 1'b0;
        end
      end
      if (take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        k_q         <= k_inc;
        first_q     <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.set_clear) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  assign sts_o.skip       = skip_q;
  assign sts_o.last       = last_q;
  assign sts_o.want_done  = (k_q == want_q);
  assign sts_o.load_order = load_order_q;
  assign sts_o.scan_done  = !scan_more && !cmp_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== hdl/k_nearest_point_select.sv =====
// top level of the k nearest point select block
// loading: a stored point passes through the states idle, mul x, mul y, mul z and store;
// a dropped point goes back to idle from mul x; selection after the last point: load order
// reads each result from the store; nearest first scans all n points through one read port
// reset: max_targets 1, origin zero, store empty; no clearing pass
module k_nearest_point_select import knps_pkg::*; #(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  point_req_t            in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output target_rsp_t           out_rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CoordBits-1:0]  cfg_wdata_i
);

  knps_cmd_t cmd;
  knps_sts_t sts;

  knps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  knps_dpath #(
    .MaxPoints (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== bench/k_nearest_point_select_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for k_nearest_point_select with a cycle-free selection predictor
module k_nearest_point_select_test import knps_pkg::*;;

  localparam int unsigned TotalItems   = 450;
  localparam int unsigned StallLimit   = 20000;
  localparam int unsigned SettleCycles = 200;

  typedef enum int unsigned {
    Spread,
    Clustered,
    Extreme
  } place_e;

  logic                  clk;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  point_req_t            in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  target_rsp_t           out_rsp_o;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CoordBits-1:0]  cfg_wdata_i;

  // predictor copy of configuration and store
  logic [LimitBits-1:0]        cfg_limit;
  logic signed [CoordBits-1:0] org_x;
  logic signed [CoordBits-1:0] org_y;
  logic signed [CoordBits-1:0] org_z;
  logic [IdBits-1:0]           id_mem [MaxPointsDef];
  logic [DistBits-1:0]         dist_mem [MaxPointsDef];
  int unsigned                 stored_cnt;
  bit                          dropped;

  point_req_t  point_queue [$];
  target_rsp_t expected_targets [$];
  int unsigned reqs_queued;
  int unsigned reqs_accepted;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  int unsigned idle_pct;
  logic        req_taken;

  k_nearest_point_select #(
    .MAX_POINTS(MaxPointsDef)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #1 clk = ~clk;

  function automatic logic [DistBits-1:0] point_dist(point_req_t p);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'($signed(p.pos_x)) - longint'(org_x);
    dy = longint'($signed(p.pos_y)) - longint'(org_y);
    dz = longint'($signed(p.pos_z)) - longint'(org_z);
    return DistBits'(dx * dx + dy * dy + dz * dz);
  endfunction

  task automatic load_point(point_req_t p);
    int unsigned          want;
    int unsigned          pick;
    bit                   in_order;
    bit                   found;
    bit [MaxPointsDef-1:0] used;
    logic [DistBits-1:0]  best;
    target_rsp_t          r;
    if (stored_cnt < MaxPointsDef) begin
      id_mem[stored_cnt] = p.point_id;
      dist_mem[stored_cnt] = point_dist(p);
      stored_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!p.last_point) return;
    in_order = !dropped && (stored_cnt <= cfg_limit);
    want = in_order ? stored_cnt : ((cfg_limit < stored_cnt) ? cfg_limit : stored_cnt);
    if (want > ResultCap) want = ResultCap;
    used = '0;
    best = '0;
    for (int unsigned k = 0; k < want; k++) begin
      pick = k;
      if (!in_order) begin
        found = 1'b0;
        pick = 0;
        for (int unsigned i = 0; i < stored_cnt; i++) begin
          if (!used[i] && (!found || dist_mem[i] < best)) begin
            found = 1'b1;
            best = dist_mem[i];
            pick = i;
          end
        end
        used[pick] = 1'b1;
      end
      r.target_id = id_mem[pick];
      r.last_target = (k + 1 == want);
      r.set_truncated = dropped;
      expected_targets.push_back(r);
    end
    stored_cnt = 0;
    dropped = 1'b0;
  endtask

  function automatic logic [CoordBits-1:0] pick_coord(place_e mode,
                                                      logic [CoordBits-1:0] center);
    case (mode)
      Clustered: return center + CoordBits'($urandom_range(6)) - CoordBits'(3);
      Extreme: begin
        case ($urandom_range(3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return '0;
          default: return CoordBits'($urandom());
        endcase
      end
      default: return CoordBits'($urandom());
    endcase
  endfunction

  function automatic logic [CoordBits-1:0] pick_origin();
    case ($urandom_range(3))
      0: return '0;
      1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return CoordBits'($urandom());
    endcase
  endfunction

  task automatic push_point(logic [IdBits-1:0] id, int x, int y, int z, bit last);
    point_req_t p;
    p.point_id = id;
    p.pos_x = x[CoordBits-1:0];
    p.pos_y = y[CoordBits-1:0];
    p.pos_z = z[CoordBits-1:0];
    p.last_point = last;
    point_queue.push_back(p);
    reqs_queued++;
  endtask

  task automatic queue_set(int unsigned n, place_e mode);
    point_req_t                 p;
    logic [3*CoordBits-1:0]     key;
    logic [3*CoordBits-1:0]     seen [$];
    bit                         dup;
    seen = {};
    for (int unsigned i = 0; i < n; i++) begin
      do begin
        p.pos_x = pick_coord(mode, org_x);
        p.pos_y = pick_coord(mode, org_y);
        p.pos_z = pick_coord(mode, org_z);
        key = {p.pos_x, p.pos_y, p.pos_z};
        dup = 1'b0;
        foreach (seen[j]) if (seen[j] == key) dup = 1'b1;
      end while (dup);
      seen.push_back(key);
      case ($urandom_range(9))
        0: p.point_id = '0;
        1: p.point_id = '1;
        default: p.point_id = IdBits'($urandom());
      endcase
      p.last_point = (i == n - 1);
      point_queue.push_back(p);
      reqs_queued++;
    end
  endtask

  task automatic program_regs(logic [LimitBits-1:0] limit, logic [CoordBits-1:0] ox,
                              logic [CoordBits-1:0] oy, logic [CoordBits-1:0] oz);
    @(negedge clk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgMaxTargets;
    cfg_wdata_i <= CoordBits'(limit);
    @(negedge clk);
    cfg_idx_i <= CfgOriginX;
    cfg_wdata_i <= ox;
    @(negedge clk);
    cfg_idx_i <= CfgOriginY;
    cfg_wdata_i <= oy;
    @(negedge clk);
    cfg_idx_i <= CfgOriginZ;
    cfg_wdata_i <= oz;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    cfg_limit = limit;
    org_x = ox;
    org_y = oy;
    org_z = oz;
  endtask

  task automatic wait_idle();
    while (reqs_accepted != reqs_queued || expected_targets.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // request driver and random output ready
  always @(negedge clk) begin
    out_ready_i <= ($urandom_range(99) >= idle_pct);
    if (!in_valid_i || req_taken) begin
      if (point_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_req_i <= point_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // acceptance, result check and watchdog
  always @(posedge clk) begin
    target_rsp_t want_rsp;
    if (rst_ni) begin
      req_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        load_point(in_req_i);
        reqs_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_targets.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected target: id %h last %b trunc %b", out_rsp_o.target_id,
                     out_rsp_o.last_target, out_rsp_o.set_truncated);
        end else begin
          want_rsp = expected_targets.pop_front();
          if (out_rsp_o.target_id !== want_rsp.target_id ||
              out_rsp_o.last_target !== want_rsp.last_target ||
              out_rsp_o.set_truncated !== want_rsp.set_truncated) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"target mismatch: expected id %h last %b trunc %b, ",
                        "got id %h last %b trunc %b"},
                       want_rsp.target_id, want_rsp.last_target, want_rsp.set_truncated,
                       out_rsp_o.target_id, out_rsp_o.last_target, out_rsp_o.set_truncated);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int unsigned          phase;
    int unsigned          start;
    int unsigned          size;
    logic [LimitBits-1:0] lim;
    clk = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgMaxTargets;
    cfg_wdata_i = '0;
    req_taken = 1'b0;
    cfg_limit = 1;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    stored_cnt = 0;
    dropped = 1'b0;
    reqs_queued = 0;
    reqs_accepted = 0;
    mismatch_count = 0;
    stall_cycles = 0;
    idle_pct = 26;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // reset values: limit one, origin zero
    @(posedge clk);
    push_point(16'hFFFF, 8388607, -8388608, 8388607, 1'b1);
    push_point(16'h0001, 5, 0, 0, 1'b0);
    push_point(16'h0002, 0, -4, 0, 1'b0);
    push_point(16'h0003, 0, 0, 4, 1'b1);
    wait_idle();

    // zero limit, sets larger than the limit
    program_regs(0, 24'h800000, 24'h7FFFFF, 24'h800000);
    @(posedge clk);
    push_point(16'h1234, 0, 0, 0, 1'b1);
    push_point(16'h4321, 1, 2, 3, 1'b0);
    push_point(16'h0000, -1, -2, -3, 1'b1);
    wait_idle();

    // largest distances, load order
    program_regs(64, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    @(posedge clk);
    push_point(16'h0000, -8388608, 8388607, -8388608, 1'b0);
    push_point(16'hFFFF, 8388607, -8388608, 8388607, 1'b0);
    push_point(16'h8000, 0, 0, 0, 1'b1);
    wait_idle();

    // equal distances go to the earlier point
    program_regs(3, '0, '0, '0);
    @(posedge clk);
    push_point(16'd10, 1, 0, 0, 1'b0);
    push_point(16'd11, 0, -1, 0, 1'b0);
    push_point(16'd12, 0, 0, 1, 1'b0);
    push_point(16'd13, -1, 0, 0, 1'b0);
    push_point(16'd14, 0, 0, -2, 1'b1);
    push_point(16'd20, 100, 100, 100, 1'b0);
    push_point(16'd21, -3, 0, 0, 1'b0);
    push_point(16'd22, 2, 2, 0, 1'b1);
    wait_idle();

    phase = 0;
    while (reqs_queued < TotalItems) begin
      case ($urandom_range(5))
        0: lim = 0;
        1: lim = 1;
        2: lim = 64;
        3: lim = LimitBits'($urandom_range(64));
        default: lim = LimitBits'($urandom_range(2, 8));
      endcase
      if (phase == 0) lim = 64;
      program_regs(lim, pick_origin(), pick_origin(), pick_origin());
      idle_pct = (phase == 2) ? 0 : 26;
      @(posedge clk);
      if (phase == 0) begin
        // full store in load order, then overflows that drop the last two points and the last point
        queue_set(64, Spread);
        queue_set(66, Clustered);
        queue_set(65, Spread);
      end else begin
        start = reqs_queued;
        while (reqs_queued - start < 40 && reqs_queued < TotalItems) begin
          size = ($urandom_range(99) < 12) ? $urandom_range(60, 70) : $urandom_range(1, 10);
          queue_set(size, place_e'($urandom_range(2)));
        end
      end
      wait_idle();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/knps_pkg.sv
hdl/knps_ctrl.sv
hdl/knps_dpath.sv
hdl/k_nearest_point_select.sv
bench/k_nearest_point_select_test.sv
